### src/vvr_pkg.sv
// ----------------------------------------------------------------------------
// vvr_pkg
// Shared widths, register indexes, angle constants and the arctangent table
// of the view vector rotator.
// ----------------------------------------------------------------------------
package vvr_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    // field widths
    localparam int COORD_W    = 12;
    localparam int GAIN_W     = 16;
    localparam int VEC_W      = 16;
    localparam int PTR_W      = 14;
    localparam int DIFF_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int GUARD_BITS = 8;
    localparam int LANE_W     = 28;
    localparam int THETA_W    = 28;
    localparam int ANG_W      = 32;
    localparam int PSUM_W     = 32;
    localparam int MUL_A_W    = 28;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = 60;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 24;
    localparam int SCALE_SHIFT = 38;

    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic signed [LANE_W-1:0]  lane_t;
    typedef logic signed [THETA_W-1:0] theta_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_COL     = 3'd0,
        REG_CENTER_ROW     = 3'd1,
        REG_TURN_GAIN      = 3'd2,
        REG_START_FACING_X = 3'd3,
        REG_START_FACING_Y = 3'd4,
        REG_START_PLANE_X  = 3'd5,
        REG_START_PLANE_Y  = 3'd6
    } cfg_reg_t;

    // operation codes
    localparam logic OP_ROTATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // lane numbers of the rotation datapath
    localparam logic [1:0] LANE_FX = 2'd0;
    localparam logic [1:0] LANE_FY = 2'd1;
    localparam logic [1:0] LANE_PX = 2'd2;
    localparam logic [1:0] LANE_PY = 2'd3;

    // register reset values
    localparam logic [COORD_W-1:0] RST_CENTER_COL     = 12'd960;
    localparam logic [COORD_W-1:0] RST_CENTER_ROW     = 12'd540;
    localparam logic [GAIN_W-1:0]  RST_TURN_GAIN      = 16'd12583;
    localparam vec_t               RST_START_FACING_X = 16'sd16384;
    localparam vec_t               RST_START_FACING_Y = 16'sd0;
    localparam vec_t               RST_START_PLANE_X  = 16'sd0;
    localparam vec_t               RST_START_PLANE_Y  = 16'sd10813;

    // angles in radians: unsigned Q8.24 in ANG_W bits, signed Q3.24 for theta_t
    localparam logic [ANG_W-1:0] ANG_PI     = 32'd52707179;
    localparam logic [ANG_W-1:0] ANG_TWO_PI = 32'd105414357;
    // pi plus eight turns keeps the angle positive before reduction
    localparam logic [ANG_W-1:0] ANG_OFFSET = ANG_PI + (ANG_TWO_PI << 3);
    localparam theta_t THETA_PI      = 28'sd52707179;
    localparam theta_t THETA_HALF_PI = 28'sd26353589;

    // cordic gain compensation in Q0.30, tail depends on the stage count
    localparam longint GAIN_BASE = 652032874;
    localparam longint GAIN_TAIL = 1304065748 / 3;

    localparam logic signed [MUL_P_W-1:0] SCALE_RND =
        MUL_P_W'(64'sd1 <<< (SCALE_SHIFT - 1));

    // round(atan(2^-i) * 2^24)
    function automatic logic [ATAN_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:    val = 24'd13176795;
            5'd1:    val = 24'd7778716;
            5'd2:    val = 24'd4110060;
            5'd3:    val = 24'd2086331;
            5'd4:    val = 24'd1047214;
            5'd5:    val = 24'd524117;
            5'd6:    val = 24'd262123;
            5'd7:    val = 24'd131069;
            5'd8:    val = 24'd65536;
            5'd9:    val = 24'd32768;
            5'd10:   val = 24'd16384;
            5'd11:   val = 24'd8192;
            5'd12:   val = 24'd4096;
            5'd13:   val = 24'd2048;
            5'd14:   val = 24'd1024;
            5'd15:   val = 24'd512;
            5'd16:   val = 24'd256;
            5'd17:   val = 24'd128;
            5'd18:   val = 24'd64;
            5'd19:   val = 24'd32;
            5'd20:   val = 24'd16;
            5'd21:   val = 24'd8;
            5'd22:   val = 24'd4;
            5'd23:   val = 24'd2;
            5'd24:   val = 24'd1;
            default: val = 24'd0;
        endcase
        return val;
    endfunction

    // vector component with guard bits below
    function automatic lane_t to_lane(input vec_t v);
        return {{(LANE_W-VEC_W-GUARD_BITS){v[VEC_W-1]}}, v, {GUARD_BITS{1'b0}}};
    endfunction

    // saturate to the 16-bit signed range
    function automatic vec_t sat_vec(input logic signed [63:0] v);
        vec_t res;
        if (v > 64'sd32767)
            res = 16'sd32767;
        else if (v < -64'sd32768)
            res = -16'sd32768;
        else
            res = v[VEC_W-1:0];
        return res;
    endfunction

endpackage

### src/vvr_in_if.sv
// ----------------------------------------------------------------------------
// vvr_in_if
// Pointer item channel: operation and pointer position with valid/ready.
// ----------------------------------------------------------------------------
interface vvr_in_if;
    import vvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic signed [PTR_W-1:0] pointer_x;
    logic signed [PTR_W-1:0] pointer_y;

    modport source (output valid, operation, pointer_x, pointer_y, input ready);
    modport sink   (input valid, operation, pointer_x, pointer_y, output ready);

endinterface

### src/vvr_out_if.sv
// ----------------------------------------------------------------------------
// vvr_out_if
// View item channel: updated vectors, pitch and clamp flag with valid/ready.
// ----------------------------------------------------------------------------
interface vvr_out_if;
    import vvr_pkg::*;

    logic valid;
    logic ready;
    vec_t new_facing_x;
    vec_t new_facing_y;
    vec_t new_plane_x;
    vec_t new_plane_y;
    vec_t new_pitch;
    logic pitch_clamped;

    modport source (output valid, new_facing_x, new_facing_y, new_plane_x, new_plane_y,
                    new_pitch, pitch_clamped, input ready);
    modport sink   (input valid, new_facing_x, new_facing_y, new_plane_x, new_plane_y,
                    new_pitch, pitch_clamped, output ready);

endinterface

### src/view_vector_rotator.sv
// ----------------------------------------------------------------------------
// view_vector_rotator
// A rotate item passes the MULX, MULY, REDUCE, ANGLE, QUAD, ROTATE, SCALE and WRITE
// states before its result is registered; a load item goes from IDLE to WRITE.
// WRITE waits while an earlier result is still held. No new item is taken until
// the current one is written out; the single cordic datapath steps one stage per
// cycle and one shared multiplier serves angle, pitch and four gain corrections.
// Reset: registers and view state return to their start values, no item held.
// ----------------------------------------------------------------------------
module view_vector_rotator #(
    parameter int FRAC_BITS     = vvr_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = vvr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vvr_pkg::CFG_DATA_W-1:0] cfg_data,
    vvr_in_if.sink                         pointer,
    vvr_out_if.source                      view
);
    import vvr_pkg::*;

    localparam int StageW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int CntW   = (StageW > 3) ? StageW : 3;
    localparam logic [CntW-1:0] ReduceLast = CntW'(3);
    localparam logic [CntW-1:0] ScaleLast  = CntW'(4);
    localparam logic [CntW-1:0] RotateLast = CntW'(CORDIC_STAGES - 1);

    localparam int PitchShift = 24 - FRAC_BITS;
    localparam logic signed [MUL_P_W-1:0] PitchRnd = MUL_P_W'(64'sd1 <<< (PitchShift - 1));
    localparam logic signed [PSUM_W-1:0]  PitchLim    = PSUM_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PSUM_W-1:0]  PitchLimNeg = -PitchLim;

    localparam logic signed [MUL_B_W-1:0] GainQ30 =
        MUL_B_W'(GAIN_BASE + (GAIN_TAIL >> (2 * CORDIC_STAGES)));

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MULX   = 9'b000000010,
        ST_MULY   = 9'b000000100,
        ST_REDUCE = 9'b000001000,
        ST_ANGLE  = 9'b000010000,
        ST_QUAD   = 9'b000100000,
        ST_ROTATE = 9'b001000000,
        ST_SCALE  = 9'b010000000,
        ST_WRITE  = 9'b100000000
    } state_t;

    // control
    state_t            state_reg, state_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    // configuration registers
    logic [COORD_W-1:0] center_col_reg, center_col_next;
    logic [COORD_W-1:0] center_row_reg, center_row_next;
    logic [GAIN_W-1:0]  turn_gain_reg, turn_gain_next;
    vec_t               start_fx_reg, start_fx_next;
    vec_t               start_fy_reg, start_fy_next;
    vec_t               start_px_reg, start_px_next;
    vec_t               start_py_reg, start_py_next;

    // view state
    vec_t facing_x_reg, facing_x_next;
    vec_t facing_y_reg, facing_y_next;
    vec_t plane_x_reg, plane_x_next;
    vec_t plane_y_reg, plane_y_next;
    vec_t pitch_reg, pitch_next;

    // working registers
    logic signed [DIFF_W-1:0]  dx_reg, dx_next;
    logic signed [DIFF_W-1:0]  dy_reg, dy_next;
    logic signed [MUL_P_W-1:0] mul_p_reg, mul_p_next;
    logic [ANG_W-1:0]          ang_reg, ang_next;
    theta_t                    theta_reg, theta_next;
    lane_t                     lane_reg [4];
    lane_t                     lane_next [4];
    logic signed [PSUM_W-1:0]  pitch_sum_reg, pitch_sum_next;
    logic                      clamped_reg, clamped_next;

    // output register
    vec_t out_fx_reg, out_fx_next;
    vec_t out_fy_reg, out_fy_next;
    vec_t out_px_reg, out_px_next;
    vec_t out_py_reg, out_py_next;
    vec_t out_pitch_reg, out_pitch_next;
    logic out_clamped_reg, out_clamped_next;

    // datapath helpers
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [ANG_W-1:0]          ang_sub;
    logic signed [MUL_P_W-1:0] pitch_rnd;
    logic signed [MUL_P_W-1:0] pitch_delta;
    logic signed [PSUM_W-1:0]  pitch_ext;
    logic signed [PSUM_W-1:0]  pitch_np;
    logic                      pitch_over;
    logic signed [MUL_P_W-1:0] scale_rnd;
    logic signed [MUL_P_W-1:0] scale_q;
    vec_t                      scale_vec;
    lane_t                     fold_lane [4];
    theta_t                    fold_theta;
    lane_t                     rot_xs [2];
    lane_t                     rot_ys [2];
    lane_t                     rot_lane [4];
    theta_t                    rot_atan;
    theta_t                    rot_theta;
    logic                      rot_dir;

    // handshake outputs
    assign pointer.ready      = (state_reg == ST_IDLE);
    assign view.valid         = out_valid_reg;
    assign view.new_facing_x  = out_fx_reg;
    assign view.new_facing_y  = out_fy_reg;
    assign view.new_plane_x   = out_px_reg;
    assign view.new_plane_y   = out_py_reg;
    assign view.new_pitch     = out_pitch_reg;
    assign view.pitch_clamped = out_clamped_reg;

    // pitch step: rounded delta and clamp to plus or minus one
    assign pitch_ext   = {{(PSUM_W-VEC_W){pitch_reg[VEC_W-1]}}, pitch_reg};
    assign pitch_rnd   = mul_p_reg + PitchRnd;
    assign pitch_delta = pitch_rnd >>> PitchShift;

    always_comb
    begin
        pitch_np   = pitch_sum_reg;
        pitch_over = 1'b0;
        if (pitch_sum_reg > PitchLim)
        begin
            pitch_np   = PitchLim;
            pitch_over = 1'b1;
        end
        else if (pitch_sum_reg < PitchLimNeg)
        begin
            pitch_np   = PitchLimNeg;
            pitch_over = 1'b1;
        end
    end

    // gain correction of one lane, rounded and saturated
    assign scale_rnd = mul_p_reg + SCALE_RND;
    assign scale_q   = scale_rnd >>> SCALE_SHIFT;
    assign scale_vec = sat_vec({{(64-MUL_P_W){scale_q[MUL_P_W-1]}}, scale_q});

    // reduction step subtrahend: two pi times 8, 4, 2, 1
    assign ang_sub = ANG_TWO_PI << (2'd3 - cnt_reg[1:0]);

    // quadrant fold: exact quarter turn when beyond plus or minus pi/2
    always_comb
    begin
        fold_lane[LANE_FX] = to_lane(facing_x_reg);
        fold_lane[LANE_FY] = to_lane(facing_y_reg);
        fold_lane[LANE_PX] = to_lane(plane_x_reg);
        fold_lane[LANE_PY] = to_lane(plane_y_reg);
        fold_theta         = theta_reg;
        if (theta_reg > THETA_HALF_PI)
        begin
            fold_lane[LANE_FX] = -to_lane(facing_y_reg);
            fold_lane[LANE_FY] = to_lane(facing_x_reg);
            fold_lane[LANE_PX] = -to_lane(plane_y_reg);
            fold_lane[LANE_PY] = to_lane(plane_x_reg);
            fold_theta         = theta_reg - THETA_HALF_PI;
        end
        else if (theta_reg < -THETA_HALF_PI)
        begin
            fold_lane[LANE_FX] = to_lane(facing_y_reg);
            fold_lane[LANE_FY] = -to_lane(facing_x_reg);
            fold_lane[LANE_PX] = to_lane(plane_y_reg);
            fold_lane[LANE_PY] = -to_lane(plane_x_reg);
            fold_theta         = theta_reg + THETA_HALF_PI;
        end
    end

    // one cordic micro-rotation on both vectors
    assign rot_dir  = ~theta_reg[THETA_W-1];
    assign rot_atan = $signed({{(THETA_W-ATAN_W){1'b0}}, atan_q24(ATAN_IDX_W'(cnt_reg))});
    assign rot_theta = rot_dir ? (theta_reg - rot_atan) : (theta_reg + rot_atan);

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rot_xs[k] = lane_reg[2*k] >>> cnt_reg;
            rot_ys[k] = lane_reg[2*k+1] >>> cnt_reg;
            if (rot_dir)
            begin
                rot_lane[2*k]   = lane_reg[2*k] - rot_ys[k];
                rot_lane[2*k+1] = lane_reg[2*k+1] + rot_xs[k];
            end
            else
            begin
                rot_lane[2*k]   = lane_reg[2*k] + rot_ys[k];
                rot_lane[2*k+1] = lane_reg[2*k+1] - rot_xs[k];
            end
        end
    end

    // sequencer and next values
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        center_col_next  = center_col_reg;
        center_row_next  = center_row_reg;
        turn_gain_next   = turn_gain_reg;
        start_fx_next    = start_fx_reg;
        start_fy_next    = start_fy_reg;
        start_px_next    = start_px_reg;
        start_py_next    = start_py_reg;
        facing_x_next    = facing_x_reg;
        facing_y_next    = facing_y_reg;
        plane_x_next     = plane_x_reg;
        plane_y_next     = plane_y_reg;
        pitch_next       = pitch_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        ang_next         = ang_reg;
        theta_next       = theta_reg;
        pitch_sum_next   = pitch_sum_reg;
        clamped_next     = clamped_reg;
        out_fx_next      = out_fx_reg;
        out_fy_next      = out_fy_reg;
        out_px_next      = out_px_reg;
        out_py_next      = out_py_reg;
        out_pitch_next   = out_pitch_reg;
        out_clamped_next = out_clamped_reg;
        for (int k = 0; k < 4; k++)
            lane_next[k] = lane_reg[k];
        mul_a = {{(MUL_A_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
        mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, turn_gain_reg});

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_COL:     center_col_next = cfg_data[COORD_W-1:0];
                REG_CENTER_ROW:     center_row_next = cfg_data[COORD_W-1:0];
                REG_TURN_GAIN:      turn_gain_next  = cfg_data[GAIN_W-1:0];
                REG_START_FACING_X: start_fx_next   = cfg_data[VEC_W-1:0];
                REG_START_FACING_Y: start_fy_next   = cfg_data[VEC_W-1:0];
                REG_START_PLANE_X:  start_px_next   = cfg_data[VEC_W-1:0];
                REG_START_PLANE_Y:  start_py_next   = cfg_data[VEC_W-1:0];
                default:            ;
            endcase
        end

        // output item taken
        if (out_valid_reg && view.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pointer.valid)
                begin
                    if (pointer.operation == OP_LOAD)
                    begin
                        facing_x_next = start_fx_reg;
                        facing_y_next = start_fy_reg;
                        plane_x_next  = start_px_reg;
                        plane_y_next  = start_py_reg;
                        pitch_next    = '0;
                        clamped_next  = 1'b0;
                        state_next    = ST_WRITE;
                    end
                    else
                    begin
                        dx_next = $signed({pointer.pointer_x[PTR_W-1], pointer.pointer_x})
                                - $signed({{(DIFF_W-COORD_W){1'b0}}, center_col_reg});
                        dy_next = $signed({pointer.pointer_y[PTR_W-1], pointer.pointer_y})
                                - $signed({{(DIFF_W-COORD_W){1'b0}}, center_row_reg});
                        state_next = ST_MULX;
                    end
                end
            end
            ST_MULX:
            begin
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                // horizontal product is ready, start the vertical one
                mul_a      = {{(MUL_A_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
                ang_next   = mul_p_reg[ANG_W-1:0] + ANG_OFFSET;
                cnt_next   = '0;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (cnt_reg == '0)
                    pitch_sum_next = pitch_ext + $signed(pitch_delta[PSUM_W-1:0]);
                if (ang_reg >= ang_sub)
                    ang_next = ang_reg - ang_sub;
                if (cnt_reg == ReduceLast)
                begin
                    cnt_next   = '0;
                    state_next = ST_ANGLE;
                end
                else
                    cnt_next = cnt_reg + CntW'(1);
            end
            ST_ANGLE:
            begin
                // rotation angle is the negated reduced angle: pi - remainder
                theta_next   = THETA_PI - $signed({1'b0, ang_reg[THETA_W-2:0]});
                pitch_next   = sat_vec({{(64-PSUM_W){pitch_np[PSUM_W-1]}}, pitch_np});
                clamped_next = pitch_over;
                state_next   = ST_QUAD;
            end
            ST_QUAD:
            begin
                for (int k = 0; k < 4; k++)
                    lane_next[k] = fold_lane[k];
                theta_next = fold_theta;
                cnt_next   = '0;
                state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                for (int k = 0; k < 4; k++)
                    lane_next[k] = rot_lane[k];
                theta_next = rot_theta;
                if (cnt_reg == RotateLast)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
                else
                    cnt_next = cnt_reg + CntW'(1);
            end
            ST_SCALE:
            begin
                // issue lane cnt, retire lane cnt - 1
                mul_a = lane_reg[cnt_reg[1:0]];
                mul_b = GainQ30;
                if (cnt_reg != '0)
                begin
                    unique case (2'(cnt_reg - CntW'(1)))
                        LANE_FX: facing_x_next = scale_vec;
                        LANE_FY: facing_y_next = scale_vec;
                        LANE_PX: plane_x_next  = scale_vec;
                        LANE_PY: plane_y_next  = scale_vec;
                        default: ;
                    endcase
                end
                if (cnt_reg == ScaleLast)
                begin
                    cnt_next   = '0;
                    state_next = ST_WRITE;
                end
                else
                    cnt_next = cnt_reg + CntW'(1);
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || view.ready)
                begin
                    out_fx_next      = facing_x_reg;
                    out_fy_next      = facing_y_reg;
                    out_px_next      = plane_x_reg;
                    out_py_next      = plane_y_reg;
                    out_pitch_next   = pitch_reg;
                    out_clamped_next = clamped_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // shared multiplier
        mul_p_next = mul_a * mul_b;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            center_col_reg <= RST_CENTER_COL;
            center_row_reg <= RST_CENTER_ROW;
            turn_gain_reg  <= RST_TURN_GAIN;
            start_fx_reg   <= RST_START_FACING_X;
            start_fy_reg   <= RST_START_FACING_Y;
            start_px_reg   <= RST_START_PLANE_X;
            start_py_reg   <= RST_START_PLANE_Y;
            facing_x_reg   <= 16'sd16384;
            facing_y_reg   <= 16'sd0;
            plane_x_reg    <= 16'sd0;
            plane_y_reg    <= 16'sd10813;
            pitch_reg      <= 16'sd0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            turn_gain_reg  <= turn_gain_next;
            start_fx_reg   <= start_fx_next;
            start_fy_reg   <= start_fy_next;
            start_px_reg   <= start_px_next;
            start_py_reg   <= start_py_next;
            facing_x_reg   <= facing_x_next;
            facing_y_reg   <= facing_y_next;
            plane_x_reg    <= plane_x_next;
            plane_y_reg    <= plane_y_next;
            pitch_reg      <= pitch_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        mul_p_reg       <= mul_p_next;
        ang_reg         <= ang_next;
        theta_reg       <= theta_next;
        pitch_sum_reg   <= pitch_sum_next;
        clamped_reg     <= clamped_next;
        for (int k = 0; k < 4; k++)
            lane_reg[k] <= lane_next[k];
        out_fx_reg      <= out_fx_next;
        out_fy_reg      <= out_fy_next;
        out_px_reg      <= out_px_next;
        out_py_reg      <= out_py_next;
        out_pitch_reg   <= out_pitch_next;
        out_clamped_reg <= out_clamped_next;
    end

    // a new result only appears from the write state
    a_valid_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared outside the write state");

    // reduction leaves the angle below one full turn
    a_angle_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ANGLE) |-> (ang_reg < ANG_TWO_PI))
        else $error("angle reduction incomplete");

    // cordic starts inside plus or minus pi/2, a turn of exactly pi folds to one above
    a_theta_folded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE && cnt_reg == '0)
            |-> (theta_reg <= THETA_PI - THETA_HALF_PI && theta_reg >= -THETA_HALF_PI))
        else $error("quadrant fold left angle out of range");

    // pitch never leaves plus or minus one
    a_pitch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_ext <= PitchLim && pitch_ext >= PitchLimNeg))
        else $error("pitch beyond its limit");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the view vector rotator. Pointer items are queued by
// a stimulus process and offered by a clocked driver; every accepted item runs
// through a local model of the view state (angle reduction, quadrant turn,
// cordic with gain correction, pitch update with clamping) and its expected
// view item is checked field by field against what the block returns.
// ----------------------------------------------------------------------------
module tb;
    import vvr_pkg::*;

    localparam int     STAGES        = CORDIC_STAGES_DEF;
    localparam int     FRAC          = FRAC_BITS_DEF;
    localparam longint TURN_PI       = 64'sd52707179;
    localparam longint TURN_TWO_PI   = 64'sd105414357;
    localparam longint TURN_HALF_PI  = 64'sd26353589;
    localparam longint VIEW_K_Q30    =
        64'sd652032874 + ((64'sd1304065748 / 3) >> (2 * STAGES));
    localparam longint PITCH_ONE     = 64'sd1 << FRAC;
    localparam int     PITCH_SHIFT   = 24 - FRAC;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int     PHASE_ITEMS   = 175;
    localparam int     HOLD_CYCLES   = 500;
    localparam int     TAIL_CYCLES   = 40;

    typedef struct packed {
        logic                    op;
        logic signed [PTR_W-1:0] px;
        logic signed [PTR_W-1:0] py;
    } ptr_item_t;

    typedef struct packed {
        vec_t fx;
        vec_t fy;
        vec_t px;
        vec_t py;
        vec_t pitch;
        logic clamped;
    } view_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vvr_in_if  pointer_if ();
    vvr_out_if view_if ();

    // items waiting to be offered and views waiting to come back
    ptr_item_t  pointer_items[$];
    view_item_t expected_views[$];

    int mismatches = 0;
    int send_idle_pct;
    int recv_stall_pct;
    int ready_hold_cycles = 0;
    // hold-off requests from the stimulus and those already started
    int hold_requests = 0;
    int hold_served = 0;

    // model copy of the registers
    logic [COORD_W-1:0] cfg_center_col;
    logic [COORD_W-1:0] cfg_center_row;
    logic [GAIN_W-1:0]  cfg_turn_gain;
    vec_t               cfg_start_fx;
    vec_t               cfg_start_fy;
    vec_t               cfg_start_px;
    vec_t               cfg_start_py;

    // model copy of the view state, at its reset values
    vec_t view_fx    = 16'sd16384;
    vec_t view_fy    = 16'sd0;
    vec_t view_px    = 16'sd0;
    vec_t view_py    = 16'sd10813;
    vec_t view_pitch = 16'sd0;

    view_vector_rotator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pointer   (pointer_if),
        .view      (view_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    // saturate to the signed 16-bit range
    function automatic vec_t clip_vec(input longint v);
        if (v > 64'sd32767)
            return 16'sd32767;
        if (v < -64'sd32768)
            return -16'sd32768;
        return vec_t'(v);
    endfunction

    // round(atan(2^-i) * 2^24)
    function automatic longint atan_step(input int i);
        return longint'($rtoi($floor($atan(1.0 / (2.0 ** i)) * 16777216.0 + 0.5)));
    endfunction

    // turn one vector by theta (signed q39.24 radians) with quadrant pre-turn and cordic
    function automatic void turn_pair(inout vec_t cx, inout vec_t cy, input longint theta);
        longint x;
        longint y;
        longint t;
        longint xs;
        longint ys;
        x = longint'(cx) * 256;
        y = longint'(cy) * 256;
        if (theta > TURN_HALF_PI)
        begin
            t = x;
            x = -y;
            y = t;
            theta -= TURN_HALF_PI;
        end
        else if (theta < -TURN_HALF_PI)
        begin
            t = x;
            x = y;
            y = -t;
            theta += TURN_HALF_PI;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (theta >= 0)
            begin
                x -= ys;
                y += xs;
                theta -= atan_step(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                theta += atan_step(i);
            end
        end
        // gain correction, round half up
        x = (x * VIEW_K_Q30 + (64'sd1 <<< 37)) >>> 38;
        y = (y * VIEW_K_Q30 + (64'sd1 <<< 37)) >>> 38;
        cx = clip_vec(x);
        cy = clip_vec(y);
    endfunction

    // advance the view state by one pointer item and give the resulting view
    function automatic view_item_t predict_view(input ptr_item_t it);
        view_item_t res;
        longint     dx;
        longint     dy;
        longint     gain;
        longint     ang;
        longint     np;
        res.clamped = 1'b0;
        if (it.op == OP_LOAD)
        begin
            view_fx    = cfg_start_fx;
            view_fy    = cfg_start_fy;
            view_px    = cfg_start_px;
            view_py    = cfg_start_py;
            view_pitch = '0;
        end
        else
        begin
            gain = longint'(cfg_turn_gain);
            dx   = longint'(it.px) - longint'(cfg_center_col);
            dy   = longint'(it.py) - longint'(cfg_center_row);
            // reduce the angle to [-pi, pi)
            ang  = (dx * gain + TURN_PI) % TURN_TWO_PI;
            if (ang < 0)
                ang += TURN_TWO_PI;
            ang -= TURN_PI;
            turn_pair(view_fx, view_fy, -ang);
            turn_pair(view_px, view_py, -ang);
            // pitch step with rounding and clamp at plus or minus one
            np = longint'(view_pitch)
                 + ((dy * gain + (64'sd1 <<< (PITCH_SHIFT - 1))) >>> PITCH_SHIFT);
            if (np > PITCH_ONE)
            begin
                np = PITCH_ONE;
                res.clamped = 1'b1;
            end
            else if (np < -PITCH_ONE)
            begin
                np = -PITCH_ONE;
                res.clamped = 1'b1;
            end
            view_pitch = clip_vec(np);
        end
        res.fx    = view_fx;
        res.fy    = view_fy;
        res.px    = view_px;
        res.py    = view_py;
        res.pitch = view_pitch;
        return res;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // driver: offers queued pointer items, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        ptr_item_t taken;
        ptr_item_t offer;
        if (!rst_n)
        begin
            pointer_if.valid     <= 1'b0;
            pointer_if.operation <= OP_ROTATE;
            pointer_if.pointer_x <= '0;
            pointer_if.pointer_y <= '0;
        end
        else
        begin
            if (pointer_if.valid && pointer_if.ready)
            begin
                taken.op = pointer_if.operation;
                taken.px = pointer_if.pointer_x;
                taken.py = pointer_if.pointer_y;
                expected_views.push_back(predict_view(taken));
            end
            if (!pointer_if.valid || pointer_if.ready)
            begin
                if (pointer_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offer = pointer_items.pop_front();
                    pointer_if.valid     <= 1'b1;
                    pointer_if.operation <= offer.op;
                    pointer_if.pointer_x <= offer.px;
                    pointer_if.pointer_y <= offer.py;
                end
                else
                begin
                    pointer_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started on request and counted down here
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served       <= hold_requests;
            ready_hold_cycles <= HOLD_CYCLES;
        end
        else if (ready_hold_cycles != 0)
            ready_hold_cycles <= ready_hold_cycles - 1;
    end

    // monitor: drives ready and checks each view item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        view_item_t want;
        if (!rst_n)
        begin
            view_if.ready <= 1'b0;
        end
        else
        begin
            if (view_if.valid && view_if.ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("view item with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    check_field("new_facing_x", want.fx, view_if.new_facing_x);
                    check_field("new_facing_y", want.fy, view_if.new_facing_y);
                    check_field("new_plane_x", want.px, view_if.new_plane_x);
                    check_field("new_plane_y", want.py, view_if.new_plane_y);
                    check_field("new_pitch", want.pitch, view_if.new_pitch);
                    check_field("pitch_clamped", want.clamped, view_if.pitch_clamped);
                end
            end
            view_if.ready <= (ready_hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(input logic op, input int px, input int py);
        ptr_item_t it;
        it.op = op;
        it.px = px[PTR_W-1:0];
        it.py = py[PTR_W-1:0];
        pointer_items.push_back(it);
    endtask

    // wait until every queued item is taken and every view has come back
    task automatic drain();
        while (pointer_items.size() != 0 || pointer_if.valid || expected_views.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        unique case (idx)
            REG_CENTER_COL:     cfg_center_col = data[COORD_W-1:0];
            REG_CENTER_ROW:     cfg_center_row = data[COORD_W-1:0];
            REG_TURN_GAIN:      cfg_turn_gain  = data[GAIN_W-1:0];
            REG_START_FACING_X: cfg_start_fx   = data;
            REG_START_FACING_Y: cfg_start_fy   = data;
            REG_START_PLANE_X:  cfg_start_px   = data;
            REG_START_PLANE_Y:  cfg_start_py   = data;
            default:            ; // unknown index, write dropped
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_view(input logic [15:0] col, input logic [15:0] row,
                                input logic [15:0] gain, input logic [15:0] sfx,
                                input logic [15:0] sfy, input logic [15:0] spx,
                                input logic [15:0] spy);
        write_reg(REG_CENTER_COL, col);
        write_reg(REG_CENTER_ROW, row);
        write_reg(REG_TURN_GAIN, gain);
        write_reg(REG_START_FACING_X, sfx);
        write_reg(REG_START_FACING_Y, sfy);
        write_reg(REG_START_PLANE_X, spx);
        write_reg(REG_START_PLANE_Y, spy);
    endtask

    function automatic logic [15:0] pick_vec();
        if ($urandom_range(99) < 30)
            return 16'($urandom_range(65535));
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    // stimulus
    initial
    begin
        int px;
        int py;
        int gain;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        cfg_center_col = RST_CENTER_COL;
        cfg_center_row = RST_CENTER_ROW;
        cfg_turn_gain  = RST_TURN_GAIN;
        cfg_start_fx   = RST_START_FACING_X;
        cfg_start_fy   = RST_START_FACING_Y;
        cfg_start_px   = RST_START_PLANE_X;
        cfg_start_py   = RST_START_PLANE_Y;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: centre, field extremes, load, both quadrant turns, wrap near pi
        queue_item(OP_ROTATE, 960, 540);
        queue_item(OP_ROTATE, 8191, 8191);
        queue_item(OP_ROTATE, -8192, -8192);
        queue_item(OP_LOAD, -8192, 8191);
        queue_item(OP_ROTATE, 960 + 2800, 540);
        queue_item(OP_ROTATE, 960 - 2800, 540);
        queue_item(OP_ROTATE, 960 + 4189, 540);
        queue_item(OP_ROTATE, 960 - 4188, 540);
        drain();

        // unit gain so the pitch steps by whole pixels; saturating start vectors
        program_view(16'd0, 16'd0, 16'd1024, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        write_reg(REG_UNUSED, 16'($urandom_range(65535)));
        queue_item(OP_LOAD, 8191, -8192);
        queue_item(OP_ROTATE, 0, 8191);
        queue_item(OP_ROTATE, 8191, 8191);
        // pitch lands on exactly one, then goes past it
        queue_item(OP_ROTATE, -8192, 2);
        queue_item(OP_ROTATE, -4096, 1);
        // walk down to exactly minus one, then past it
        repeat (4) queue_item(OP_ROTATE, 0, -8192);
        queue_item(OP_ROTATE, 1234, -1);
        drain();

        // largest gain and centres
        program_view(16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        queue_item(OP_LOAD, 0, 0);
        queue_item(OP_ROTATE, -8192, -8192);
        queue_item(OP_ROTATE, 8191, 8191);
        drain();

        // zero gain
        write_reg(REG_TURN_GAIN, 16'd0);
        queue_item(OP_ROTATE, 100, -5000);
        queue_item(OP_ROTATE, 8191, 0);
        drain();

        // random phases, two settings per idling pattern
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                3:       program_view(16'd0, 16'd0, 16'd1, 16'h8000, 16'h8000,
                                      16'h8000, 16'h8000);
                6:       program_view(16'd4095, 16'd4095, 16'hffff, 16'h7fff, 16'h7fff,
                                      16'h7fff, 16'h7fff);
                default:
                begin
                    gain = ($urandom_range(99) < 30) ? $urandom_range(65535)
                                                     : $urandom_range(2000, 30000);
                    program_view(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'(gain), pick_vec(), pick_vec(), pick_vec(), pick_vec());
                end
            endcase

            case (p / 2)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase

            // receiver holds off while the sender keeps offering
            if (p == 0)
                hold_requests++;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    queue_item(OP_LOAD, $urandom_range(16383), $urandom_range(16383));
                end
                else if ($urandom_range(99) < 60)
                begin
                    // near the centre, so the pitch moves without always clamping
                    px = int'(cfg_center_col) + int'($urandom_range(600)) - 300;
                    py = int'(cfg_center_row) + int'($urandom_range(600)) - 300;
                    queue_item(OP_ROTATE, px, py);
                end
                else
                begin
                    queue_item(OP_ROTATE, $urandom_range(16383), $urandom_range(16383));
                end
            end
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
